// ----- design/cqw_pkg.sv -----
// shared types, codes and helpers for the csv cell quoting writer
`timescale 1ns / 1ps

package cqw_pkg;

    // default cell buffer depth in bytes
    localparam int CELL_BYTES_DEF = 16;

    // request codes carried in the low tuser bits
    localparam logic [1:0] REQ_BYTE   = 2'd0;
    localparam logic [1:0] REQ_EMPTY  = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    // output characters
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] BOM_B0   = 8'hEF;
    localparam logic [7:0] BOM_B1   = 8'hBB;
    localparam logic [7:0] BOM_B2   = 8'hBF;

    // separator owed ahead of the current job
    typedef enum logic [1:0] {
        SEP_NONE,
        SEP_BOM,
        SEP_LF,
        SEP_COMMA
    } sep_t;

    // byte source for one output item
    typedef enum logic [2:0] {
        SEL_BOM0,
        SEL_BOM1,
        SEL_BOM2,
        SEL_COMMA,
        SEL_LF,
        SEL_QUOTE,
        SEL_CELL
    } sel_t;

    // controller to datapath
    typedef struct packed {
        logic emit;
        sel_t sel;
        logic last;
        logic ptr_rst;
        logic ptr_inc;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        sep_t sep;
        logic job_cell;
        logic quoted;
        logic mark0;
        logic mark_next;
        logic more;
        logic out_free;
    } sts_t;

    // utf-8 character length from its lead byte, invalid leads count as one
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        begin
            if (b[7] == 1'b0) len = 3'd1;
            else if ((b & 8'd224) == 8'd192) len = 3'd2;
            else if ((b & 8'd240) == 8'd224) len = 3'd3;
            else if ((b & 8'd248) == 8'd240) len = 3'd4;
            else if ((b & 8'd252) == 8'd248) len = 3'd5;
            else if ((b & 8'd254) == 8'd252) len = 3'd6;
            else len = 3'd1;
            return len;
        end
    endfunction

endpackage

// ----- design/cqw_dp.sv -----
// datapath: cell buffer, quoting scan, job registers and output register
`timescale 1ns / 1ps

module cqw_dp import cqw_pkg::*; #(
    parameter int CELL_BYTES = CELL_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       acc,
    input  logic [1:0] req_type,
    input  logic [7:0] data_byte,
    input  logic       new_row,
    input  logic       check_quoting,
    input  logic       last_in_cell,
    input  logic       cfg_valid,
    input  logic       cfg_data,
    input  cmd_t       cmd,
    output sts_t       sts,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    localparam int CNT_W = $clog2(CELL_BYTES + 1);
    localparam int IDX_W = (CELL_BYTES > 1) ? $clog2(CELL_BYTES) : 1;

    // cell buffer
    logic [7:0] store_mem [CELL_BYTES];
    logic [7:0] rd_data_reg;

    // cell scan state
    logic [CELL_BYTES-1:0] marks_reg, marks_next, marks_cur;
    logic [CNT_W-1:0]      cnt_reg, cnt_next, cnt_cur;
    logic                  nq_reg, nq_next, nq_cur;
    logic [2:0]            skip_reg, skip_next, skip_cur;
    logic                  in_cell_reg, in_cell_next;
    logic                  row_reg, row_next, row_cur;
    logic                  chk_reg, chk_next, chk_cur;
    logic                  ovf_reg, ovf_next, ovf_cur;
    logic                  started_reg, started_next;
    logic                  bom_reg;

    // job registers
    sep_t                  job_sep_reg, job_sep_next;
    logic                  job_cell_reg, job_cell_next;
    logic                  job_trunc_reg, job_trunc_next;

    // replay pointer and output register
    logic [IDX_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      ptr_plus;
    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg, out_byte;
    logic                  out_last_reg;
    logic                  out_trunc_reg;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic                  room;
    logic [2:0]            lead;
    logic                  sep_row;
    sep_t                  sep_open;

    // values seen by an item, a new cell starts from cleared state
    always_comb begin
        cnt_cur   = in_cell_reg ? cnt_reg   : '0;
        marks_cur = in_cell_reg ? marks_reg : '0;
        nq_cur    = in_cell_reg ? nq_reg    : 1'b0;
        skip_cur  = in_cell_reg ? skip_reg  : 3'd0;
        ovf_cur   = in_cell_reg ? ovf_reg   : 1'b0;
        row_cur   = in_cell_reg ? row_reg   : new_row;
        chk_cur   = in_cell_reg ? chk_reg   : check_quoting;
        room      = (cnt_cur < CNT_W'(CELL_BYTES));
        wr_idx    = cnt_cur[IDX_W-1:0];
        lead      = lead_len(data_byte);
    end

    // item intake and job setup
    always_comb begin
        cnt_next       = cnt_reg;
        marks_next     = marks_reg;
        nq_next        = nq_reg;
        skip_next      = skip_reg;
        in_cell_next   = in_cell_reg;
        row_next       = row_reg;
        chk_next       = chk_reg;
        ovf_next       = ovf_reg;
        started_next   = started_reg;
        job_sep_next   = job_sep_reg;
        job_cell_next  = job_cell_reg;
        job_trunc_next = job_trunc_reg;
        wr_en          = 1'b0;
        if (acc) begin
            job_sep_next   = SEP_NONE;
            job_cell_next  = 1'b0;
            job_trunc_next = 1'b0;
            unique case (req_type)
                REQ_BYTE: begin
                    in_cell_next = 1'b1;
                    row_next     = row_cur;
                    chk_next     = chk_cur;
                    cnt_next     = cnt_cur;
                    marks_next   = marks_cur;
                    nq_next      = nq_cur;
                    skip_next    = skip_cur;
                    ovf_next     = ovf_cur;
                    if (room) begin
                        wr_en = 1'b1;
                        if (skip_cur == 3'd0) begin
                            if (lead == 3'd1) begin
                                if (data_byte == CH_COMMA || data_byte == CH_LF ||
                                    data_byte == CH_CR) begin
                                    nq_next = 1'b1;
                                end else if (data_byte == CH_QUOTE) begin
                                    nq_next            = 1'b1;
                                    marks_next[wr_idx] = 1'b1;
                                end
                            end
                            skip_next = lead - 3'd1;
                        end else begin
                            skip_next = skip_cur - 3'd1;
                        end
                        cnt_next = cnt_cur + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (last_in_cell) begin
                        in_cell_next   = 1'b0;
                        job_cell_next  = 1'b1;
                        job_trunc_next = ovf_next;
                        job_sep_next   = sep_open;
                        started_next   = 1'b1;
                    end
                end
                REQ_EMPTY: begin
                    in_cell_next = 1'b0;
                    job_sep_next = sep_open;
                    started_next = 1'b1;
                end
                REQ_FINISH: begin
                    in_cell_next = 1'b0;
                    job_sep_next = started_reg ? SEP_LF : SEP_NONE;
                    started_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // separator ahead of a cell, a closing byte takes the row flag of its cell
    always_comb begin
        sep_row = (req_type == REQ_BYTE) ? row_cur : new_row;
        if (started_reg) sep_open = sep_row ? SEP_LF : SEP_COMMA;
        else             sep_open = bom_reg ? SEP_BOM : SEP_NONE;
    end

    // replay pointer
    always_comb begin
        if (cmd.ptr_rst)      rd_ptr_next = '0;
        else if (cmd.ptr_inc) rd_ptr_next = rd_ptr_reg + IDX_W'(1);
        else                  rd_ptr_next = rd_ptr_reg;
    end

    // output byte select
    always_comb begin
        case (cmd.sel)
            SEL_BOM0:  out_byte = BOM_B0;
            SEL_BOM1:  out_byte = BOM_B1;
            SEL_BOM2:  out_byte = BOM_B2;
            SEL_COMMA: out_byte = CH_COMMA;
            SEL_LF:    out_byte = CH_LF;
            SEL_QUOTE: out_byte = CH_QUOTE;
            SEL_CELL:  out_byte = rd_data_reg;
            default:   out_byte = CH_LF;
        endcase
    end

    // status for the controller
    always_comb begin
        ptr_plus      = CNT_W'(rd_ptr_reg) + CNT_W'(1);
        sts.sep       = job_sep_reg;
        sts.job_cell  = job_cell_reg;
        sts.quoted    = chk_reg & nq_reg;
        sts.mark0     = marks_reg[0];
        sts.more      = (ptr_plus < cnt_reg);
        sts.mark_next = sts.more ? marks_reg[ptr_plus[IDX_W-1:0]] : 1'b0;
        sts.out_free  = !out_valid_reg || m_tready;
    end

    // buffer write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_idx] <= data_byte;
        end
        rd_data_reg <= store_mem[rd_ptr_next];
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            marks_reg     <= '0;
            nq_reg        <= 1'b0;
            skip_reg      <= 3'd0;
            in_cell_reg   <= 1'b0;
            row_reg       <= 1'b0;
            chk_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            started_reg   <= 1'b0;
            bom_reg       <= 1'b0;
            job_sep_reg   <= SEP_NONE;
            job_cell_reg  <= 1'b0;
            job_trunc_reg <= 1'b0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            marks_reg     <= marks_next;
            nq_reg        <= nq_next;
            skip_reg      <= skip_next;
            in_cell_reg   <= in_cell_next;
            row_reg       <= row_next;
            chk_reg       <= chk_next;
            ovf_reg       <= ovf_next;
            started_reg   <= started_next;
            job_sep_reg   <= job_sep_next;
            job_cell_reg  <= job_cell_next;
            job_trunc_reg <= job_trunc_next;
            rd_ptr_reg    <= rd_ptr_next;
            if (cfg_valid) begin
                bom_reg <= cfg_data;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_byte_reg  <= out_byte;
            out_last_reg  <= cmd.last;
            out_trunc_reg <= job_trunc_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_trunc_reg;

endmodule

// ----- design/cqw_ctrl.sv -----
// controller: sequences separator, quotes and cell replay one byte at a time
`timescale 1ns / 1ps

module cqw_ctrl import cqw_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic acc,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SEP,
        ST_OPEN,
        ST_MARK,
        ST_BYTE,
        ST_CLOSE
    } state_t;

    state_t     state_reg, state_next, cell_first;
    logic [1:0] bom_idx_reg, bom_idx_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;

    // first state of the cell body
    always_comb begin
        if (sts.job_cell) cell_first = sts.quoted ? ST_OPEN : ST_BYTE;
        else              cell_first = ST_IDLE;
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        bom_idx_next = bom_idx_reg;
        cmd.emit     = 1'b0;
        cmd.sel      = SEL_QUOTE;
        cmd.ptr_rst  = 1'b0;
        cmd.ptr_inc  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    state_next  = ST_DECIDE;
                    cmd.ptr_rst = 1'b1;
                end
            end
            ST_DECIDE: begin
                bom_idx_next = 2'd0;
                if (sts.sep != SEP_NONE) state_next = ST_SEP;
                else                     state_next = cell_first;
            end
            ST_SEP: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    unique case (sts.sep)
                        SEP_BOM: begin
                            cmd.sel = (bom_idx_reg == 2'd0) ? SEL_BOM0 :
                                      (bom_idx_reg == 2'd1) ? SEL_BOM1 : SEL_BOM2;
                        end
                        SEP_COMMA: cmd.sel = SEL_COMMA;
                        default:   cmd.sel = SEL_LF;
                    endcase
                    if (sts.sep == SEP_BOM && bom_idx_reg != 2'd2) begin
                        bom_idx_next = bom_idx_reg + 2'd1;
                    end else begin
                        state_next = cell_first;
                    end
                end
            end
            ST_OPEN: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = sts.mark0 ? ST_MARK : ST_BYTE;
                end
            end
            ST_MARK: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_BYTE;
                end
            end
            ST_BYTE: begin
                if (sts.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.sel     = SEL_CELL;
                    cmd.ptr_inc = 1'b1;
                    if (sts.more) begin
                        state_next = (sts.quoted && sts.mark_next) ? ST_MARK : ST_BYTE;
                    end else begin
                        state_next = sts.quoted ? ST_CLOSE : ST_IDLE;
                    end
                end
            end
            ST_CLOSE: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // a byte is the last of its item when the job ends with it
        cmd.last = cmd.emit && (state_next == ST_IDLE);
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bom_idx_reg <= 2'd0;
        end else begin
            state_reg   <= state_next;
            bom_idx_reg <= bom_idx_next;
        end
    end

`ifndef NO_ASSERTIONS
    // never overwrite a result still waiting downstream
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("emit while output register is occupied");

    // an accepted item is always followed by the decide step
    a_acc_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |=> (state_reg == ST_DECIDE))
        else $error("accepted item did not reach decide");

    // the marked last byte closes the job
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |=> s_tready)
        else $error("last byte emitted but block not ready");

    // quote doubling only happens inside a quoted cell
    a_mark_quoted: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MARK) |-> sts.quoted)
        else $error("quote doubling outside a quoted cell");
`endif

endmodule

// ----- design/csv_cell_quoting_writer_top.sv -----
// top level of the csv cell quoting writer
//
//   channel   direction  tdata             tuser / data           tlast
//   s_*       in         data_byte         req_type,new_row,chk   last_in_cell
//   m_*       out        out_byte          cell_truncated         run_last
//   cfg_*     in         -                 cfg_data = emit_bom    -
//
// an item is accepted in the idle state and passes a decide step, then gives one
// result per cycle while m_tready is high; a byte that does not end a cell gives
// no result and goes back to idle after the decide step
// the output register and the one-byte-per-cycle replay of the cell buffer
// set that rate
// reset is synchronous on aresetn low and clears all control state
// a stall on m_tready holds the controller in place, s_tready stays low
`timescale 1ns / 1ps

module csv_cell_quoting_writer_top import cqw_pkg::*; #(
    parameter int CELL_BYTES = CELL_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    input  logic [3:0] s_tuser,   // [1:0] req_type, [2] new_row, [3] check_quoting
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic       m_tuser,   // [0] cell_truncated
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic acc;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // sequencer
    cqw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .acc      (acc),
        .sts      (sts),
        .cmd      (cmd)
    );

    // buffer, scan and output register
    cqw_dp #(
        .CELL_BYTES (CELL_BYTES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .acc           (acc),
        .req_type      (s_tuser[1:0]),
        .data_byte     (s_tdata),
        .new_row       (s_tuser[2]),
        .check_quoting (s_tuser[3]),
        .last_in_cell  (s_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .sts           (sts),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser)
    );

endmodule

// ----- tb/sv/csv_writer_checker.sv -----
// csv writer checker: expected output bytes predicted from the observed input and config items
`timescale 1ns / 1ps

module csv_writer_checker import cqw_pkg::*; #(
    parameter int CELL_BYTES = CELL_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    input  logic [3:0] s_tuser,   // [1:0] req_type, [2] new_row, [3] check_quoting
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    input  logic       m_tlast,
    input  logic       m_tuser,   // [0] cell_truncated
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_data,
    output int         mismatches,
    output int         pending,
    output int         bytes_checked
);

    localparam int CW = $clog2(CELL_BYTES + 1);
    localparam int IW = (CELL_BYTES > 1) ? $clog2(CELL_BYTES) : 1;

    // one expected output item
    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       trunc;
    } csv_out_t;

    csv_out_t         csv_expected_q[$];
    logic [7:0]       item_bytes[$];

    // shadow copy of the writer state
    logic [7:0]            cell_buf [CELL_BYTES];
    logic [CELL_BYTES-1:0] quote_marks;
    logic [CW-1:0]         fill;
    logic                  quote_needed;
    logic [2:0]            cont_left;
    logic                  cell_open;
    logic                  row_flag;
    logic                  chk_flag;
    logic                  dropped;
    logic                  table_open;
    logic                  bom_on;

    // utf-8 character span from the top bits of its first byte
    function automatic logic [2:0] utf8_span(input logic [7:0] b);
        casez (b)
            8'b0???????: return 3'd1;
            8'b110?????: return 3'd2;
            8'b1110????: return 3'd3;
            8'b11110???: return 3'd4;
            8'b111110??: return 3'd5;
            8'b1111110?: return 3'd6;
            default:     return 3'd1;
        endcase
    endfunction

    task automatic report(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] csv check: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // bom (when enabled) before the first cell of a table, else comma or lf
    task automatic put_sep(input logic row);
        if (!table_open) begin
            if (bom_on) begin
                item_bytes.push_back(BOM_B0);
                item_bytes.push_back(BOM_B1);
                item_bytes.push_back(BOM_B2);
            end
            table_open = 1'b1;
        end else begin
            item_bytes.push_back(row ? CH_LF : CH_COMMA);
        end
    endtask

    // update shadow state for one input item and queue the bytes it produces
    task automatic predict_csv(input logic [1:0] req, input logic [7:0] b, input logic nr,
                               input logic cq, input logic is_last);
        logic     quoted;
        logic     cut;
        int       i;
        csv_out_t e;
        item_bytes.delete();
        cut = 1'b0;
        case (req)
            REQ_BYTE: begin
                if (!cell_open) begin
                    cell_open    = 1'b1;
                    row_flag     = nr;
                    chk_flag     = cq;
                    fill         = '0;
                    quote_marks  = '0;
                    quote_needed = 1'b0;
                    cont_left    = 3'd0;
                    dropped      = 1'b0;
                end
                if (fill < CW'(CELL_BYTES)) begin
                    cell_buf[fill[IW-1:0]] = b;
                    // only a one-byte character can force quoting
                    if (cont_left == 3'd0) begin
                        if (utf8_span(b) == 3'd1) begin
                            if (b == CH_COMMA || b == CH_LF || b == CH_CR) begin
                                quote_needed = 1'b1;
                            end else if (b == CH_QUOTE) begin
                                quote_needed             = 1'b1;
                                quote_marks[fill[IW-1:0]] = 1'b1;
                            end
                        end
                        cont_left = utf8_span(b) - 3'd1;
                    end else begin
                        cont_left = cont_left - 3'd1;
                    end
                    fill = fill + CW'(1);
                end else begin
                    dropped = 1'b1;
                end
                // cell closes: separator, then raw or quoted text
                if (is_last) begin
                    put_sep(row_flag);
                    quoted = chk_flag && quote_needed;
                    if (quoted) item_bytes.push_back(CH_QUOTE);
                    for (i = 0; i < int'(fill); i++) begin
                        if (quoted && quote_marks[IW'(i)]) item_bytes.push_back(CH_QUOTE);
                        item_bytes.push_back(cell_buf[IW'(i)]);
                    end
                    if (quoted) item_bytes.push_back(CH_QUOTE);
                    cut       = dropped;
                    cell_open = 1'b0;
                end
            end
            REQ_EMPTY: begin
                cell_open = 1'b0;
                put_sep(nr);
            end
            REQ_FINISH: begin
                cell_open = 1'b0;
                if (table_open) item_bytes.push_back(CH_LF);
                table_open = 1'b0;
            end
            default: ;
        endcase
        for (i = 0; i < item_bytes.size(); i++) begin
            e.ch      = item_bytes[i];
            e.run_end = (i == item_bytes.size() - 1);
            e.trunc   = cut;
            csv_expected_q.push_back(e);
        end
    endtask

    // compare accepted output items first, then predict from accepted input
    always @(posedge aclk) begin
        csv_out_t want;
        if (!aresetn) begin
            csv_expected_q.delete();
            quote_marks   = '0;
            fill          = '0;
            quote_needed  = 1'b0;
            cont_left     = 3'd0;
            cell_open     = 1'b0;
            row_flag      = 1'b0;
            chk_flag      = 1'b0;
            dropped       = 1'b0;
            table_open    = 1'b0;
            bom_on        = 1'b0;
            mismatches    = 0;
            pending       = 0;
            bytes_checked = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                bytes_checked++;
                if (csv_expected_q.size() == 0) begin
                    report("output item with nothing expected", m_tdata, 0);
                end else begin
                    want = csv_expected_q.pop_front();
                    if (m_tdata !== want.ch) report("out_byte", m_tdata, want.ch);
                    if (m_tlast !== want.run_end) report("run_last", m_tlast, want.run_end);
                    if (m_tuser !== want.trunc) report("cell_truncated", m_tuser, want.trunc);
                end
            end
            if (cfg_valid && cfg_ready) bom_on = cfg_data;
            if (s_tvalid && s_tready)
                predict_csv(s_tuser[1:0], s_tdata, s_tuser[2], s_tuser[3], s_tlast);
            pending = csv_expected_q.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// testbench top: clock, reset, stimulus, receiver stalls, watchdog and verdict
`timescale 1ns / 1ps

module testbench;
    import cqw_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         IDLE_LIMIT  = 400;
    localparam int         DRAIN_WAIT  = 8;
    localparam int         PHASES      = 6;
    localparam int         PHASE_ITEMS = 46;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tlast   = 1'b0;
    logic [3:0] s_tuser   = 4'h0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;

    int mismatches;
    int pending;
    int bytes_checked;
    int items_sent  = 0;
    int cells_sent  = 0;
    int long_cells  = 0;
    int bom_writes  = 0;
    int idle_cycles = 0;
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;

    always #2 aclk = ~aclk;

    csv_cell_quoting_writer_top #(
        .CELL_BYTES(CELL_BYTES_DEF)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    csv_writer_checker #(
        .CELL_BYTES(CELL_BYTES_DEF)
    ) csv_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .mismatches(mismatches), .pending(pending), .bytes_checked(bytes_checked)
    );

    // per-item wait, with occasional stretches of back-to-back traffic
    task automatic pick_gap(inout bit calm, output int gap);
        if ($urandom_range(0, 24) == 0) calm = !calm;
        gap = calm ? 0 : $urandom_range(0, 14);
    endtask

    // drive one input item and hold it until accepted
    task automatic send_item(input logic [1:0] req, input logic [7:0] data, input logic nr,
                             input logic cq, input logic is_last);
        int gap;
        pick_gap(tx_calm, gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= data;
        s_tuser  <= {cq, nr, req};
        s_tlast  <= is_last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (req != REQ_UNUSED) items_sent++;
    endtask

    // stop sending and wait until every expected byte is out
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_bom(input logic val);
        settle();
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        bom_writes++;
    endtask

    // mostly plain text, with specials, utf-8 sequences and stray bytes
    task automatic pick_text_byte(inout int cont, output logic [7:0] b);
        int k;
        if (cont > 0 && $urandom_range(0, 7) != 0) begin
            b = {2'b10, 6'($urandom_range(0, 63))};
            cont--;
        end else begin
            cont = 0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: b = 8'($urandom_range(8'h20, 8'h7E));
                5, 6: begin
                    case ($urandom_range(0, 3))
                        0:       b = CH_COMMA;
                        1:       b = CH_QUOTE;
                        2:       b = CH_CR;
                        default: b = CH_LF;
                    endcase
                end
                7: begin
                    k = $urandom_range(2, 6);
                    b = 8'($urandom_range(0, 255));
                    case (k)
                        2:       b = {3'b110, b[4:0]};
                        3:       b = {4'b1110, b[3:0]};
                        4:       b = {5'b11110, b[2:0]};
                        5:       b = {6'b111110, b[1:0]};
                        default: b = {7'b1111110, b[0]};
                    endcase
                    cont = k - 1;
                end
                8:       b = 8'($urandom_range(0, 255));
                default: b = 8'($urandom_range(8'h80, 8'hFF));
            endcase
        end
    endtask

    // mostly short cells, some up to the buffer, a few past it
    function automatic int pick_cell_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(1, 6);
        if (r < 9) return $urandom_range(7, 16);
        return $urandom_range(17, 22);
    endfunction

    // one cell of random text; an aborted cell is cut off by an empty or finish request
    task automatic drive_cell(input int len, input bit abort);
        int         cont;
        int         i;
        logic [7:0] b;
        logic       nr;
        logic       cq;
        cont = 0;
        nr   = 1'($urandom_range(0, 1));
        cq   = ($urandom_range(0, 3) != 0);
        for (i = 0; i < len; i++) begin
            pick_text_byte(cont, b);
            if (i > 0) begin
                nr = 1'($urandom_range(0, 1));
                cq = 1'($urandom_range(0, 1));
            end
            send_item(REQ_BYTE, b, nr, cq, (i == len - 1) && !abort);
        end
        if (abort)
            send_item($urandom_range(0, 1) ? REQ_EMPTY : REQ_FINISH, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        cells_sent++;
        if (len > CELL_BYTES_DEF) long_cells++;
    endtask

    // receiver: random stall ahead of each output item
    initial begin
        int gap;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            pick_gap(rx_calm, gap);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // stimulus
    initial begin
        int p;
        int goal;
        int r;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: bom off from reset
        send_item(REQ_EMPTY, 8'h00, 1'b0, 1'b0, 1'b0);    // empty first cell gives nothing
        send_item(REQ_BYTE, 8'h61, 1'b0, 1'b1, 1'b1);     // checked but needs no quotes
        send_item(REQ_BYTE, CH_QUOTE, 1'b1, 1'b1, 1'b0);  // quote doubled, comma inside
        send_item(REQ_BYTE, CH_COMMA, 1'b0, 1'b0, 1'b0);
        send_item(REQ_BYTE, 8'hFF, 1'b0, 1'b0, 1'b1);
        send_item(REQ_BYTE, 8'hC3, 1'b0, 1'b1, 1'b0);     // quote byte inside a two-byte char
        send_item(REQ_BYTE, CH_QUOTE, 1'b0, 1'b1, 1'b1);
        send_item(REQ_BYTE, 8'hE2, 1'b1, 1'b1, 1'b0);     // three-byte char cut short
        send_item(REQ_BYTE, 8'h82, 1'b0, 1'b1, 1'b1);
        send_item(REQ_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1);   // ignored request code
        send_item(REQ_BYTE, 8'h78, 1'b0, 1'b1, 1'b0);     // open cell dropped by empty cell
        send_item(REQ_EMPTY, 8'h00, 1'b1, 1'b0, 1'b0);
        send_item(REQ_BYTE, CH_LF, 1'b0, 1'b0, 1'b0);     // open cell dropped by finish
        send_item(REQ_FINISH, 8'h00, 1'b0, 1'b0, 1'b1);
        send_item(REQ_FINISH, 8'hFF, 1'b1, 1'b1, 1'b0);   // finish with no table open

        // directed: bom on
        write_bom(1'b1);
        send_item(REQ_BYTE, 8'h00, 1'b1, 1'b1, 1'b1);
        send_item(REQ_BYTE, CH_CR, 1'b0, 1'b1, 1'b1);
        send_item(REQ_BYTE, CH_LF, 1'b1, 1'b0, 1'b1);     // unchecked, goes out raw
        send_item(REQ_EMPTY, 8'hFF, 1'b0, 1'b1, 1'b1);
        send_item(REQ_FINISH, 8'h00, 1'b0, 1'b0, 1'b0);
        send_item(REQ_EMPTY, 8'h55, 1'b1, 1'b0, 1'b1);    // empty first cell, bom only
        send_item(REQ_FINISH, 8'hAA, 1'b1, 1'b1, 1'b0);

        // random phases, bom toggled between them
        for (p = 0; p < PHASES; p++) begin
            write_bom(p[0]);
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                r = $urandom_range(0, 19);
                case (r)
                    0: send_item(REQ_EMPTY, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                    1: send_item(REQ_FINISH, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                    2: send_item(REQ_UNUSED, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                    3:       drive_cell(pick_cell_len(), 1'b1);
                    default: drive_cell(pick_cell_len(), 1'b0);
                endcase
            end
        end

        settle();
        $display("run covered %0d input items, %0d random cells (%0d past the buffer)",
                 items_sent, cells_sent, long_cells);
        $display("%0d output bytes checked across %0d bom setting changes",
                 bytes_checked, bom_writes);
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/cqw_pkg.sv
design/cqw_dp.sv
design/cqw_ctrl.sv
design/csv_cell_quoting_writer_top.sv
tb/sv/csv_writer_checker.sv
tb/sv/testbench.sv
